[sv/jsu_pkg.sv]
// Shared types, codes and helpers for the JSON string unescaper.
// Used by json_string_unescape_utf8 and its port checker; no dependencies.
`default_nettype none

package jsu_pkg;

    // result kinds
    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_COMPLETE = 2'd1;
    localparam logic [1:0] KIND_ERROR    = 2'd2;

    // error codes
    localparam logic [1:0] ERR_UNTERM_STR = 2'd0;
    localparam logic [1:0] ERR_UNTERM_ESC = 2'd1;
    localparam logic [1:0] ERR_BAD_HEX    = 2'd2;
    localparam logic [1:0] ERR_BAD_ESC    = 2'd3;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;

    // most result words one source byte can cause
    localparam int unsigned MAX_RES = 6;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic [1:0] err;
    } t_res;

    typedef struct packed {
        logic [3:0][7:0] b;   // b[0] goes out first
        logic [2:0]      n;
    } t_utf8;

    // {ok, value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // simple escapes: {ok, decoded byte}
    function automatic logic [8:0] esc_map(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            8'h22:   r = {1'b1, 8'h22};
            8'h5C:   r = {1'b1, 8'h5C};
            8'h2F:   r = {1'b1, 8'h2F};
            8'h62:   r = {1'b1, 8'h08};
            8'h66:   r = {1'b1, 8'h0C};
            8'h6E:   r = {1'b1, 8'h0A};
            8'h72:   r = {1'b1, 8'h0D};
            8'h74:   r = {1'b1, 8'h09};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic t_utf8 utf8_encode(input logic [20:0] cp);
        t_utf8 r;
        r = '0;
        if (cp < 21'h80) begin
            r.b[0] = cp[7:0];
            r.n    = 3'd1;
        end else if (cp < 21'h800) begin
            r.b[0] = {3'b110, cp[10:6]};
            r.b[1] = {2'b10, cp[5:0]};
            r.n    = 3'd2;
        end else if (cp < 21'h10000) begin
            r.b[0] = {4'b1110, cp[15:12]};
            r.b[1] = {2'b10, cp[11:6]};
            r.b[2] = {2'b10, cp[5:0]};
            r.n    = 3'd3;
        end else begin
            r.b[0] = {5'b11110, cp[20:18]};
            r.b[1] = {2'b10, cp[17:12]};
            r.b[2] = {2'b10, cp[11:6]};
            r.b[3] = {2'b10, cp[5:0]};
            r.n    = 3'd4;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/json_string_unescape_utf8.sv]
// JSON string literal unescaper with UTF-8 output: top level.
// Depends on jsu_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one source byte per word,
//   or an end-of-source marker (i_source_end). The first byte of a literal is
//   taken as its opening quote. Output channel (o_out_valid / i_out_ready)
//   carries decoded UTF-8 bytes, then a completion word at the closing quote,
//   or an error word; o_last flags the final word caused by one input byte.
//   The first result word appears in the cycle after acceptance.
//   One input byte per cycle while each byte causes at most one result and
//   the receiver is ready; a byte causing more results holds the input while
//   the result buffer drains one word a cycle (when the receiver is ready).
//   Bytes that cause no result (backslash, hex digits) do not stall the input.
//   The next byte is taken in the cycle the last buffered word leaves, so a
//   stream without expansion runs back to back.
//   A stalled receiver holds the current word; the input stalls once the
//   buffer holds more than the word being taken.
//   Reset (synchronous, active low) returns to waiting for an opening quote
//   and empties the result buffer.
`default_nettype none

module json_string_unescape_utf8 (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_source_end,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic [1:0]      o_kind,
    output logic [1:0]      o_error_code,
    output logic            o_last
);

    localparam logic [2:0] PH_WAIT      = 3'd0;
    localparam logic [2:0] PH_BODY      = 3'd1;
    localparam logic [2:0] PH_ESC       = 3'd2;
    localparam logic [2:0] PH_HEX       = 3'd3;
    localparam logic [2:0] PH_AFTER_HI  = 3'd4;
    localparam logic [2:0] PH_PAIR_BS   = 3'd5;
    localparam logic [2:0] PH_PAIR_HEX  = 3'd6;

    logic [2:0]  r_phase, n_phase;
    logic [15:0] r_acc, n_acc;
    logic [1:0]  r_dig, n_dig;
    logic [15:0] r_pend, n_pend;

    jsu_pkg::t_res r_buf [jsu_pkg::MAX_RES];
    jsu_pkg::t_res n_buf [jsu_pkg::MAX_RES];
    logic [2:0]    r_cnt, n_cnt;

    logic in_acc, out_take;

    // per-byte decode outputs: code point A, code point B, then a single word S
    logic          a_en, b_en, s_en;
    logic [20:0]   a_cp, b_cp;
    jsu_pkg::t_res s_res;
    logic          do_body, do_esc, do_fail;
    logic [1:0]    fail_code;
    logic [4:0]    hv;
    logic [8:0]    em;
    logic          hx_ok;
    logic [15:0]   acc_new;

    assign o_out_valid = (r_cnt != 3'd0);
    assign out_take    = o_out_valid & i_out_ready;
    assign o_in_ready  = (r_cnt == 3'd0) || (r_cnt == 3'd1 && i_out_ready);
    assign in_acc      = i_in_valid & o_in_ready;

    assign o_out_byte   = r_buf[0].data;
    assign o_kind       = r_buf[0].kind;
    assign o_error_code = r_buf[0].err;
    assign o_last       = (r_cnt == 3'd1);

    assign hv      = jsu_pkg::hex_value(i_data_byte);
    assign em      = jsu_pkg::esc_map(i_data_byte);
    assign hx_ok   = !i_source_end && hv[4];
    assign acc_new = {r_acc[11:0], hv[3:0]};

    always_comb begin
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_dig     = r_dig;
        n_pend    = r_pend;
        a_en      = 1'b0;
        a_cp      = {5'd0, r_pend};
        b_en      = 1'b0;
        b_cp      = '0;
        s_en      = 1'b0;
        s_res     = '0;
        do_body   = 1'b0;
        do_esc    = 1'b0;
        do_fail   = 1'b0;
        fail_code = jsu_pkg::ERR_UNTERM_STR;

        case (r_phase)
            PH_BODY: begin
                if (i_source_end) begin
                    do_fail = 1'b1;
                end else begin
                    do_body = 1'b1;
                end
            end
            PH_ESC: begin
                if (i_source_end) begin
                    do_fail   = 1'b1;
                    fail_code = jsu_pkg::ERR_UNTERM_ESC;
                end else begin
                    do_esc = 1'b1;
                end
            end
            PH_HEX: begin
                if (!hx_ok) begin
                    do_fail   = 1'b1;
                    fail_code = jsu_pkg::ERR_BAD_HEX;
                end else begin
                    n_acc = acc_new;
                    if (r_dig == 2'd3) begin
                        n_dig = 2'd0;
                        if (acc_new >= 16'hD800 && acc_new <= 16'hDBFF) begin
                            n_pend  = acc_new;
                            n_phase = PH_AFTER_HI;
                        end else begin
                            b_en    = 1'b1;
                            b_cp    = {5'd0, acc_new};
                            n_phase = PH_BODY;
                        end
                    end else begin
                        n_dig = r_dig + 2'd1;
                    end
                end
            end
            PH_AFTER_HI: begin
                if (!i_source_end && i_data_byte == jsu_pkg::CH_BSL) begin
                    n_phase = PH_PAIR_BS;
                end else begin
                    a_en   = 1'b1;
                    n_pend = '0;
                    if (i_source_end) begin
                        do_fail = 1'b1;
                    end else begin
                        do_body = 1'b1;
                    end
                end
            end
            PH_PAIR_BS: begin
                if (!i_source_end && i_data_byte == jsu_pkg::CH_U) begin
                    n_phase = PH_PAIR_HEX;
                    n_acc   = '0;
                    n_dig   = '0;
                end else begin
                    a_en   = 1'b1;
                    n_pend = '0;
                    if (i_source_end) begin
                        do_fail   = 1'b1;
                        fail_code = jsu_pkg::ERR_UNTERM_ESC;
                    end else begin
                        do_esc = 1'b1;
                    end
                end
            end
            PH_PAIR_HEX: begin
                if (!hx_ok) begin
                    a_en      = 1'b1;
                    do_fail   = 1'b1;
                    fail_code = jsu_pkg::ERR_BAD_HEX;
                end else begin
                    n_acc = acc_new;
                    if (r_dig != 2'd3) begin
                        n_dig = r_dig + 2'd1;
                    end else begin
                        n_dig  = 2'd0;
                        n_pend = '0;
                        if (acc_new >= 16'hDC00 && acc_new <= 16'hDFFF) begin
                            // surrogate pair: 0x10000 + (hi - D800) << 10 + (lo - DC00)
                            b_en    = 1'b1;
                            b_cp    = 21'h10000 + {1'b0, r_pend[9:0], acc_new[9:0]};
                            n_phase = PH_BODY;
                        end else begin
                            a_en = 1'b1;
                            if (acc_new >= 16'hD800 && acc_new <= 16'hDBFF) begin
                                n_pend  = acc_new;
                                n_phase = PH_AFTER_HI;
                            end else begin
                                b_en    = 1'b1;
                                b_cp    = {5'd0, acc_new};
                                n_phase = PH_BODY;
                            end
                        end
                    end
                end
            end
            default: begin
                // waiting for the opening quote; the byte itself is not checked
                if (i_source_end) begin
                    do_fail = 1'b1;
                end else begin
                    n_phase = PH_BODY;
                    n_acc   = '0;
                    n_dig   = '0;
                    n_pend  = '0;
                end
            end
        endcase

        if (do_body) begin
            n_phase = PH_BODY;
            if (i_data_byte == jsu_pkg::CH_QUOTE) begin
                s_en       = 1'b1;
                s_res.kind = jsu_pkg::KIND_COMPLETE;
                n_phase    = PH_WAIT;
            end else if (i_data_byte == jsu_pkg::CH_BSL) begin
                n_phase = PH_ESC;
            end else begin
                // raw bytes, 0x80 and above included, pass unchanged
                s_en       = 1'b1;
                s_res.data = i_data_byte;
            end
        end

        if (do_esc) begin
            if (i_data_byte == jsu_pkg::CH_U) begin
                n_phase = PH_HEX;
                n_acc   = '0;
                n_dig   = '0;
            end else if (em[8]) begin
                s_en       = 1'b1;
                s_res.data = em[7:0];
                n_phase    = PH_BODY;
            end else begin
                do_fail   = 1'b1;
                fail_code = jsu_pkg::ERR_BAD_ESC;
            end
        end

        if (do_fail) begin
            s_en       = 1'b1;
            s_res.data = '0;
            s_res.kind = jsu_pkg::KIND_ERROR;
            s_res.err  = fail_code;
            n_phase    = PH_WAIT;
            n_acc      = '0;
            n_dig      = '0;
            n_pend     = '0;
        end
    end

    // pack A, B and S into the result list
    jsu_pkg::t_utf8 ea, eb;
    logic [2:0]     na, nb, nab, n_new;

    assign ea    = jsu_pkg::utf8_encode(a_cp);
    assign eb    = jsu_pkg::utf8_encode(b_cp);
    assign na    = a_en ? ea.n : 3'd0;
    assign nb    = b_en ? eb.n : 3'd0;
    assign nab   = na + nb;
    assign n_new = nab + {2'd0, s_en};

    always_comb begin
        logic [2:0] k;
        logic [2:0] kb;
        for (int i = 0; i < jsu_pkg::MAX_RES; i++) begin
            k  = 3'(i);
            kb = k - na;
            n_buf[i] = s_res;
            if (k < na) begin
                n_buf[i] = '{data: ea.b[k[1:0]], kind: jsu_pkg::KIND_BYTE,
                             err: jsu_pkg::ERR_UNTERM_STR};
            end else if (k < nab) begin
                n_buf[i] = '{data: eb.b[kb[1:0]], kind: jsu_pkg::KIND_BYTE,
                             err: jsu_pkg::ERR_UNTERM_STR};
            end
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (in_acc) begin
            n_cnt = n_new;
        end else if (out_take) begin
            n_cnt = r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_acc   <= '0;
            r_dig   <= '0;
            r_pend  <= '0;
            r_cnt   <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (in_acc) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_dig   <= n_dig;
                r_pend  <= n_pend;
            end
        end
    end

    // result buffer: loads on accept, shifts towards entry 0 as words leave
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_buf <= n_buf;
        end else if (out_take) begin
            for (int i = 0; i < jsu_pkg::MAX_RES - 1; i++) begin
                r_buf[i] <= r_buf[i + 1];
            end
        end
    end

endmodule

`default_nettype wire

[sv/jsu_checker.sv]
// Port-level checker for json_string_unescape_utf8, attached by bind.
// Depends on jsu_pkg.
`default_nettype none

module jsu_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] o_out_byte,
    input wire logic [1:0] o_kind,
    input wire logic [1:0] o_error_code,
    input wire logic       o_last
);

    // a held word stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_kind) && $stable(o_error_code) && $stable(o_last))
        else $error("output word changed while stalled");

    // completion and error words always close the words of their byte
    a_term_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == jsu_pkg::KIND_COMPLETE || o_kind == jsu_pkg::KIND_ERROR)
            |-> o_last)
        else $error("terminal word not flagged last");

    // words of one byte leave without a gap
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last |=> o_out_valid)
        else $error("gap inside a multi-word result");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != jsu_pkg::KIND_BYTE |-> o_out_byte == 8'd0)
        else $error("non-byte word carries data");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != jsu_pkg::KIND_ERROR |-> o_error_code == 2'd0)
        else $error("error code set on non-error word");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_out_byte   (o_out_byte),
    .o_kind       (o_kind),
    .o_error_code (o_error_code),
    .o_last       (o_last)
);

`default_nettype wire

[verif/tb_json_string_unescape_utf8.sv]
`timescale 1ns / 100ps
// Testbench for json_string_unescape_utf8: feeds JSON string literals a byte a word and
// checks every result word against a behavioural decoder held in a small scoreboard class.
// Depends on jsu_pkg and the block; self-contained otherwise.

module tb_json_string_unescape_utf8;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned HOLD_CYCLES  = 60;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned PHASE_WORDS  = 105;

    typedef struct packed {
        logic       src_end;
        logic [7:0] data;
    } t_src_word;

    // Decoder state tracking and the queue of result words still owed by the block
    class unescape_scoreboard;
        localparam int unsigned REPORT_LIMIT = 10;
        localparam logic [1:0]  NO_ERR       = 2'd0;

        typedef enum logic [3:0] {
            SCAN_WAIT, SCAN_BODY, SCAN_ESC, SCAN_HEX,
            SCAN_AFTER_HIGH, SCAN_PAIR_BSL, SCAN_PAIR_HEX
        } t_scan_phase;

        typedef struct packed {
            logic [7:0] data;
            logic [1:0] kind;
            logic [1:0] err;
            logic       last;
        } t_result_word;

        t_result_word expected_q[$];
        t_result_word batch[$];
        t_scan_phase  state;
        logic [15:0]  accum;
        logic [1:0]   ndigits;
        logic [15:0]  held_high;
        int unsigned  mismatches;

        function new();
            clear_state();
            mismatches = 0;
        endfunction

        static function int hex_nibble(input logic [7:0] c);
            if (c >= "0" && c <= "9") return c - "0";
            if (c >= "a" && c <= "f") return c - "a" + 10;
            if (c >= "A" && c <= "F") return c - "A" + 10;
            return -1;
        endfunction

        function void clear_state();
            state     = SCAN_WAIT;
            accum     = '0;
            ndigits   = '0;
            held_high = '0;
        endfunction

        function void push_result(input logic [7:0] d, input logic [1:0] k, input logic [1:0] e);
            batch.push_back('{data: d, kind: k, err: e, last: 1'b0});
        endfunction

        function void put_byte(input logic [7:0] d);
            push_result(d, jsu_pkg::KIND_BYTE, NO_ERR);
        endfunction

        function void put_code_point(input int unsigned cp);
            if (cp < 'h80) begin
                put_byte(8'(cp));
            end else if (cp < 'h800) begin
                put_byte(8'hC0 | 8'(cp >> 6));
                put_byte(8'h80 | 8'(cp & 'h3F));
            end else if (cp < 'h10000) begin
                put_byte(8'hE0 | 8'(cp >> 12));
                put_byte(8'h80 | 8'((cp >> 6) & 'h3F));
                put_byte(8'h80 | 8'(cp & 'h3F));
            end else begin
                put_byte(8'hF0 | 8'((cp >> 18) & 'h07));
                put_byte(8'h80 | 8'((cp >> 12) & 'h3F));
                put_byte(8'h80 | 8'((cp >> 6) & 'h3F));
                put_byte(8'h80 | 8'(cp & 'h3F));
            end
        endfunction

        function void abort(input logic [1:0] code);
            push_result(8'h00, jsu_pkg::KIND_ERROR, code);
            clear_state();
        endfunction

        function void take_body(input logic [7:0] b);
            state = SCAN_BODY;
            if (b == jsu_pkg::CH_QUOTE) begin
                push_result(8'h00, jsu_pkg::KIND_COMPLETE, NO_ERR);
                state = SCAN_WAIT;
            end else if (b == jsu_pkg::CH_BSL) begin
                state = SCAN_ESC;
            end else begin
                put_byte(b);
            end
        endfunction

        function void take_escape(input logic [7:0] b);
            state = SCAN_BODY;
            case (b)
                "\"", "\\", "/": put_byte(b);
                "b": put_byte(8'h08);
                "f": put_byte(8'h0C);
                "n": put_byte(8'h0A);
                "r": put_byte(8'h0D);
                "t": put_byte(8'h09);
                "u": begin
                    state   = SCAN_HEX;
                    accum   = '0;
                    ndigits = '0;
                end
                default: abort(jsu_pkg::ERR_BAD_ESC);
            endcase
        endfunction

        // a high surrogate is held back until we know whether a low one follows
        function void settle_code(input logic [15:0] cu);
            if (cu >= 16'hD800 && cu <= 16'hDBFF) begin
                held_high = cu;
                state     = SCAN_AFTER_HIGH;
            end else begin
                put_code_point(cu);
                state = SCAN_BODY;
            end
        endfunction

        function void record_input(input logic [7:0] b, input logic e);
            int           h;
            int unsigned  high;
            t_result_word w;
            batch.delete();
            case (state)
                SCAN_BODY: begin
                    if (e) abort(jsu_pkg::ERR_UNTERM_STR);
                    else take_body(b);
                end
                SCAN_ESC: begin
                    if (e) abort(jsu_pkg::ERR_UNTERM_ESC);
                    else take_escape(b);
                end
                SCAN_HEX: begin
                    h = e ? -1 : hex_nibble(b);
                    if (h < 0) begin
                        abort(jsu_pkg::ERR_BAD_HEX);
                    end else begin
                        accum = {accum[11:0], 4'(h)};
                        if (ndigits == 2'd3) begin
                            ndigits = '0;
                            settle_code(accum);
                        end else begin
                            ndigits++;
                        end
                    end
                end
                SCAN_AFTER_HIGH: begin
                    if (!e && b == jsu_pkg::CH_BSL) begin
                        state = SCAN_PAIR_BSL;
                    end else begin
                        put_code_point(held_high);
                        held_high = '0;
                        if (e) abort(jsu_pkg::ERR_UNTERM_STR);
                        else take_body(b);
                    end
                end
                SCAN_PAIR_BSL: begin
                    if (!e && b == jsu_pkg::CH_U) begin
                        state   = SCAN_PAIR_HEX;
                        accum   = '0;
                        ndigits = '0;
                    end else begin
                        put_code_point(held_high);
                        held_high = '0;
                        if (e) abort(jsu_pkg::ERR_UNTERM_ESC);
                        else take_escape(b);
                    end
                end
                SCAN_PAIR_HEX: begin
                    h = e ? -1 : hex_nibble(b);
                    if (h < 0) begin
                        put_code_point(held_high);
                        abort(jsu_pkg::ERR_BAD_HEX);
                    end else begin
                        accum = {accum[11:0], 4'(h)};
                        if (ndigits != 2'd3) begin
                            ndigits++;
                        end else begin
                            ndigits   = '0;
                            high      = held_high;
                            held_high = '0;
                            if (accum >= 16'hDC00 && accum <= 16'hDFFF) begin
                                put_code_point('h10000 + ((high - 'hD800) << 10)
                                               + (accum - 'hDC00));
                                state = SCAN_BODY;
                            end else begin
                                put_code_point(high);
                                settle_code(accum);
                            end
                        end
                    end
                end
                default: begin
                    // first byte opens the literal, whatever it is
                    if (e) begin
                        abort(jsu_pkg::ERR_UNTERM_STR);
                    end else begin
                        clear_state();
                        state = SCAN_BODY;
                    end
                end
            endcase
            foreach (batch[i]) begin
                w      = batch[i];
                w.last = (i == batch.size() - 1);
                expected_q.push_back(w);
            end
        endfunction

        function void check_result(input logic [7:0] d, input logic [1:0] k,
                                   input logic [1:0] e, input logic l);
            t_result_word want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected word: byte %h kind %0d err %0d last %0b", d, k, e, l);
                return;
            end
            want = expected_q.pop_front();
            if (d !== want.data || k !== want.kind || e !== want.err || l !== want.last) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"mismatch: expected byte %h kind %0d err %0d last %0b, ",
                              "got %h %0d %0d %0b"},
                             want.data, want.kind, want.err, want.last, d, k, e, l);
            end
        endfunction
    endclass

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic [7:0] i_data_byte  = 8'h00;
    logic       i_source_end = 1'b0;
    logic       i_out_ready  = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic [1:0] o_kind;
    logic [1:0] o_error_code;
    logic       o_last;

    unescape_scoreboard sb;
    t_src_word          src_q[$];
    int unsigned        receiver_stall_pct = 0;
    bit                 hold_req           = 1'b0;
    int unsigned        hold_left          = 0;
    int unsigned        cycle_count        = 0;

    json_string_unescape_utf8 dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_source_end (i_source_end),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_kind       (o_kind),
        .o_error_code (o_error_code),
        .o_last       (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // receiver: checks words, owns ready and the long hold-off count
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_out_byte, o_kind, o_error_code, o_last);
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    function automatic void push_src(input logic [7:0] d);
        src_q.push_back('{src_end: 1'b0, data: d});
    endfunction

    // data byte is don't-care with the end marker, so randomise it
    function automatic void push_src_end();
        src_q.push_back('{src_end: 1'b1, data: 8'($urandom)});
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return "0" + n;
        return (($urandom_range(1) != 0) ? "a" : "A") + n - 8'd10;
    endfunction

    function automatic void push_hex4(input logic [15:0] v);
        for (int i = 3; i >= 0; i--)
            push_src(hex_char(v[i*4 +: 4]));
    endfunction

    function automatic void push_uescape(input logic [15:0] v);
        push_src(jsu_pkg::CH_BSL);
        push_src(jsu_pkg::CH_U);
        push_hex4(v);
    endfunction

    function automatic logic [15:0] random_code_unit();
        case ($urandom_range(6))
            0: return 16'($urandom_range('h7F));
            1: return 16'($urandom_range('h7FF, 'h80));
            2: return 16'($urandom_range('hFFFF, 'h800));
            3: return 16'($urandom_range('hDBFF, 'hD800));
            4: return 16'($urandom_range('hDFFF, 'hDC00));
            default: begin
                case ($urandom_range(3))
                    0: return 16'h0000;
                    1: return 16'hFFFF;
                    2: return 16'h07FF;
                    default: return 16'h0800;
                endcase
            end
        endcase
    endfunction

    function automatic logic [7:0] simple_escape_char();
        case ($urandom_range(7))
            0: return "\"";
            1: return "\\";
            2: return "/";
            3: return "b";
            4: return "f";
            5: return "n";
            6: return "r";
            default: return "t";
        endcase
    endfunction

    // one literal: mostly well formed, with random content and the odd broken tail
    function automatic void push_string();
        int unsigned ntok;
        int unsigned pick;
        logic [7:0]  c;
        if ($urandom_range(9) == 0) push_src(8'($urandom));
        else push_src(jsu_pkg::CH_QUOTE);
        ntok = $urandom_range(6);
        repeat (ntok) begin
            pick = $urandom_range(19);
            if (pick < 7) begin
                do c = 8'($urandom); while (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BSL);
                push_src(c);
            end else if (pick < 11) begin
                push_src(jsu_pkg::CH_BSL);
                push_src(simple_escape_char());
            end else if (pick < 16) begin
                push_uescape(random_code_unit());
            end else begin
                push_uescape(16'($urandom_range('hDBFF, 'hD800)));
                push_uescape(16'($urandom_range('hDFFF, 'hDC00)));
            end
        end
        case ($urandom_range(11))
            0: push_src_end();
            1: begin
                push_src(jsu_pkg::CH_BSL);
                push_src_end();
            end
            2: begin
                push_src(jsu_pkg::CH_BSL);
                do c = 8'($urandom);
                while (c inside {"\"", "\\", "/", "b", "f", "n", "r", "t", "u"});
                push_src(c);
            end
            3: begin
                push_src(jsu_pkg::CH_BSL);
                push_src(jsu_pkg::CH_U);
                repeat ($urandom_range(3)) push_src(hex_char(4'($urandom)));
                if ($urandom_range(1) == 0) begin
                    push_src_end();
                end else begin
                    do c = 8'($urandom); while (unescape_scoreboard::hex_nibble(c) >= 0);
                    push_src(c);
                end
            end
            default: push_src(jsu_pkg::CH_QUOTE);
        endcase
    endfunction

    function automatic void build_directed();
        push_src_end();                 // end of source while waiting
        push_src(jsu_pkg::CH_QUOTE);
        push_src(8'h00);
        push_src(8'hFF);
        push_src(jsu_pkg::CH_BSL);
        push_src("t");
        push_uescape(16'hDBFF);         // highest supplementary code point
        push_uescape(16'hDFFF);
        push_src(jsu_pkg::CH_QUOTE);
        push_src(jsu_pkg::CH_QUOTE);
        push_uescape(16'hD800);         // unpaired high, then the source runs out
        push_src_end();
    endfunction

    // valid stays up between back-to-back words; lowered only for idle cycles
    task automatic send_stream(input int unsigned idle_pct);
        t_src_word w;
        while (src_q.size() > 0) begin
            w = src_q.pop_front();
            while ($urandom_range(99) < idle_pct) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_in_valid   <= 1'b1;
            i_data_byte  <= w.data;
            i_source_end <= w.src_end;
            @(posedge i_clk);
            while (!o_in_ready) @(posedge i_clk);
            sb.record_input(w.data, w.src_end);
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    // shared knobs change on the falling edge, away from the receiver's sampling
    task automatic set_idling(input int unsigned stall_pct, input bit hold);
        @(negedge i_clk);
        receiver_stall_pct = stall_pct;
        hold_req           = hold;
        @(posedge i_clk);
    endtask

    initial begin
        int unsigned idle_pct;
        int unsigned stall_pct;
        bit          hold;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        build_directed();
        send_stream(0);
        wait_for_results();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  hold = 1'b1; end
                1: begin idle_pct = 69; stall_pct = 0;  hold = 1'b0; end
                2: begin idle_pct = 0;  stall_pct = 69; hold = 1'b0; end
                default: begin idle_pct = 31; stall_pct = 31; hold = 1'b0; end
            endcase
            set_idling(stall_pct, hold);
            while (src_q.size() < PHASE_WORDS) begin
                if ($urandom_range(19) == 0) push_src_end();
                push_string();
            end
            send_stream(idle_pct);
            wait_for_results();
        end

        set_idling(0, 1'b0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
